### src/led_string_fade_and_frame_tx_macros.svh
// Assertion macros for the LED string frame transmitter.
// Needs clk and rst in the scope of each use.
`ifndef LED_STRING_FADE_AND_FRAME_TX_MACROS_SVH
`define LED_STRING_FADE_AND_FRAME_TX_MACROS_SVH

`ifndef SYNTHESIS
`define LSFT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lsft assertion failed");
`define LSFT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lsft assertion failed");
`else
`define LSFT_ASSERT_SAME(label, ante, cons)
`define LSFT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### src/lsft_pkg.sv
// Package for the LED string frame transmitter: sizes, codes, state and table entry types,
// the index clamp and the colour step helper. No dependencies.
package lsft_pkg;

  localparam int BULB_COUNT = 64;
  localparam int BULB_IDX_W = (BULB_COUNT > 1) ? $clog2(BULB_COUNT) : 1;
  localparam int ADDR_W     = 6;
  localparam int LEVEL_W    = 8;
  localparam int COLOR_W    = 12;
  localparam int NIB_W      = 4;
  localparam int TIME_W     = 8;
  localparam int FRAME_BITS = ADDR_W + LEVEL_W + COLOR_W;
  localparam int BIT_CNT_W  = $clog2(FRAME_BITS + 1);

  localparam logic [ADDR_W-1:0] LAST_BULB = ADDR_W'(BULB_COUNT - 1);

  localparam logic CMD_SET     = 1'b0;
  localparam logic CMD_SERVICE = 1'b1;

  typedef enum logic [1:0] {
    REG_SHORT_TIME = 2'd0,
    REG_LONG_TIME  = 2'd1,
    REG_END_TIME   = 2'd2,
    REG_BRIGHT_LIM = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_START,
    ST_LOW,
    ST_HIGH,
    ST_END
  } state_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [COLOR_W-1:0] color;
  } entry_t;

  function automatic logic [ADDR_W-1:0] clamp_index(input logic [ADDR_W-1:0] idx);
    return (idx > LAST_BULB) ? LAST_BULB : idx;
  endfunction

  function automatic logic [NIB_W-1:0] step_nibble(input logic [NIB_W-1:0] now,
                                                   input logic [NIB_W-1:0] want);
    logic [NIB_W-1:0] res;
    if (want > now) begin
      res = now + NIB_W'(1);
    end else if (want < now) begin
      res = now - NIB_W'(1);
    end else begin
      res = now;
    end
    return res;
  endfunction

endpackage

### src/led_string_fade_and_frame_tx.sv
// LED string driver: goal/shown bulb tables and serial frame segment output.
// Depends on lsft_pkg and led_string_fade_and_frame_tx_macros.svh.
//
//   channel   direction  word
//   s_*       in         tuser cmd; tdata bulb_index, target_rgb, target_level, fade_mode
//   m_*       out        tdata pin_level, hold_us; tlast frame_end
//   apb       in/out     four 8-bit timing and limit registers at 0x0, 0x4, 0x8, 0xC
//
// A set word is taken in IDLE; an unchanged bulb's service word goes via CHECK to IDLE.
// A changed bulb passes CHECK and then sends 54 segments, one segment a cycle unless
// m_tready stalls, from a 26-bit shift register that moves one bit every two segments.
// Reset is synchronous; per-bulb valid bits make both tables read zero at once.
// Low m_tready holds the segment register and the frame sequencer with it.
`include "led_string_fade_and_frame_tx_macros.svh"

module led_string_fade_and_frame_tx
  import lsft_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // bulb_index, target_rgb, target_level, fade_mode, zeros
  input  logic [0:0]  s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // pin_level, hold_us, zeros
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [TIME_W-1:0]  short_time;
  logic [TIME_W-1:0]  long_time;
  logic [TIME_W-1:0]  end_time;
  logic [LEVEL_W-1:0] bright_limit;
  logic               cfg_wr;
  reg_idx_t           reg_idx;

  state_t state, state_next;

  logic                  in_cmd;
  logic [ADDR_W-1:0]     in_slot;
  logic [BULB_IDX_W-1:0] in_addr;
  logic                  s_accept;

  entry_t goal_mem  [BULB_COUNT];
  entry_t shown_mem [BULB_COUNT];
  logic [BULB_COUNT-1:0] goal_vld;
  logic [BULB_COUNT-1:0] shown_vld;
  entry_t goal_rd, shown_rd;
  logic   goal_ok, shown_ok;

  logic [ADDR_W-1:0]     slot;
  logic [BULB_IDX_W-1:0] slot_addr;
  logic                  fade;
  entry_t                goal, shown, shown_new;
  logic [LEVEL_W-1:0]    sent;
  logic                  changed;
  logic                  shown_wr;

  logic [FRAME_BITS-1:0] frame_sr;
  logic [BIT_CNT_W-1:0]  bit_cnt;
  logic                  shift_en;
  logic                  cur_bit;

  logic               out_free;
  logic               load_out;
  logic               out_level;
  logic [TIME_W-1:0]  out_hold;
  logic               out_last;
  logic               m_level;
  logic [TIME_W-1:0]  m_hold;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      short_time   <= TIME_W'(10);
      long_time    <= TIME_W'(20);
      end_time     <= TIME_W'(30);
      bright_limit <= LEVEL_W'(204);
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_SHORT_TIME: short_time   <= pwdata[TIME_W-1:0];
        REG_LONG_TIME:  long_time    <= pwdata[TIME_W-1:0];
        REG_END_TIME:   end_time     <= pwdata[TIME_W-1:0];
        REG_BRIGHT_LIM: bright_limit <= pwdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SHORT_TIME: prdata = {24'b0, short_time};
      REG_LONG_TIME:  prdata = {24'b0, long_time};
      REG_END_TIME:   prdata = {24'b0, end_time};
      REG_BRIGHT_LIM: prdata = {24'b0, bright_limit};
      default:        prdata = '0;
    endcase
  end

  // input side
  assign in_cmd   = s_tuser[0];
  assign in_slot  = clamp_index(s_tdata[5:0]);
  assign in_addr  = in_slot[BULB_IDX_W-1:0];
  assign s_tready = (state == ST_IDLE);
  assign s_accept = s_tvalid & s_tready;

  // tables
  always_ff @(posedge clk) begin
    if (s_accept && in_cmd == CMD_SET) begin
      goal_mem[in_addr] <= '{level: s_tdata[25:18], color: s_tdata[17:6]};
    end
    if (s_accept) begin
      goal_rd <= goal_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (shown_wr) begin
      shown_mem[slot_addr] <= shown_new;
    end
    if (s_accept) begin
      shown_rd <= shown_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_vld  <= '0;
      shown_vld <= '0;
    end else begin
      if (s_accept && in_cmd == CMD_SET) begin
        goal_vld[in_addr] <= 1'b1;
      end
      if (shown_wr) begin
        shown_vld[slot_addr] <= 1'b1;
      end
    end
  end

  // compare and new colour
  assign slot_addr = slot[BULB_IDX_W-1:0];
  assign goal      = goal_ok  ? goal_rd  : '0;
  assign shown     = shown_ok ? shown_rd : '0;
  assign changed   = (goal != shown);
  assign shown_wr  = (state == ST_CHECK) && changed;
  assign sent      = (goal.level > bright_limit) ? bright_limit : goal.level;

  always_comb begin
    shown_new.level = goal.level;
    if (fade) begin
      shown_new.color = {step_nibble(shown.color[11:8], goal.color[11:8]),
                         step_nibble(shown.color[7:4],  goal.color[7:4]),
                         step_nibble(shown.color[3:0],  goal.color[3:0])};
    end else begin
      shown_new.color = goal.color;
    end
  end

  // item registers and frame shift register
  always_ff @(posedge clk) begin
    if (s_accept) begin
      slot     <= in_slot;
      fade     <= s_tdata[26];
      goal_ok  <= goal_vld[in_addr];
      shown_ok <= shown_vld[in_addr];
    end
    if (shown_wr) begin
      frame_sr <= {slot, sent, shown_new.color};
    end else if (shift_en) begin
      frame_sr <= {frame_sr[FRAME_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_cnt <= '0;
    end else if (shown_wr) begin
      bit_cnt <= BIT_CNT_W'(FRAME_BITS);
    end else if (shift_en) begin
      bit_cnt <= bit_cnt - BIT_CNT_W'(1);
    end
  end

  assign cur_bit = frame_sr[FRAME_BITS-1];

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    out_level  = 1'b0;
    out_hold   = short_time;
    out_last   = 1'b0;
    shift_en   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_accept && in_cmd == CMD_SERVICE) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = changed ? ST_START : ST_IDLE;
      end
      ST_START: begin
        if (out_free) begin
          load_out   = 1'b1;
          out_level  = 1'b1;
          out_hold   = short_time;
          state_next = ST_LOW;
        end
      end
      ST_LOW: begin
        if (out_free) begin
          load_out   = 1'b1;
          out_level  = 1'b0;
          out_hold   = cur_bit ? long_time : short_time;
          state_next = ST_HIGH;
        end
      end
      ST_HIGH: begin
        if (out_free) begin
          load_out   = 1'b1;
          out_level  = 1'b1;
          out_hold   = cur_bit ? short_time : long_time;
          shift_en   = 1'b1;
          state_next = (bit_cnt == BIT_CNT_W'(1)) ? ST_END : ST_LOW;
        end
      end
      ST_END: begin
        if (out_free) begin
          load_out   = 1'b1;
          out_level  = 1'b0;
          out_hold   = end_time;
          out_last   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // segment register
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_level <= out_level;
      m_hold  <= out_hold;
      m_tlast <= out_last;
    end
  end

  assign m_tdata = {7'b0, m_hold, m_level};

  `LSFT_ASSERT_NEXT(a_unchanged_idle, state == ST_CHECK && !changed, state == ST_IDLE)
  `LSFT_ASSERT_NEXT(a_last_bit_end, state == ST_HIGH && out_free && bit_cnt == BIT_CNT_W'(1), state == ST_END)
  `LSFT_ASSERT_SAME(a_end_low, m_tvalid && m_tlast, m_tdata[0] == 1'b0)
  `LSFT_ASSERT_SAME(a_bits_bound, state == ST_LOW || state == ST_HIGH, bit_cnt != '0 && bit_cnt <= BIT_CNT_W'(FRAME_BITS))

endmodule

### sim/led_string_fade_and_frame_tx_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the LED string frame transmitter: stream words in,
// line segments out, timing registers over APB. Needs lsft_pkg and the RTL.
module led_string_fade_and_frame_tx_tb
  import lsft_pkg::*;
();

  typedef struct packed {
    logic       pin;
    logic [7:0] hold;
    logic       last;
  } seg_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic [LEVEL_W-1:0] goal_lvl [BULB_COUNT];
  logic [COLOR_W-1:0] goal_col [BULB_COUNT];
  logic [LEVEL_W-1:0] shown_lvl [BULB_COUNT];
  logic [COLOR_W-1:0] shown_col [BULB_COUNT];
  logic [7:0] t_short = 8'd10;
  logic [7:0] t_long = 8'd20;
  logic [7:0] t_end = 8'd30;
  logic [7:0] lvl_cap = 8'd204;

  seg_t pending_segs [$];
  int   errors = 0;
  int   burst_left = 0;
  int   hold_seq = 0;
  int   hold_seen = 0;
  int   hold_len = 0;
  int   rx_hold = 0;
  int   rx_phase = 0;
  int   rx_stall_pct = 0;

  led_string_fade_and_frame_tx DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void push_seg(logic pin, logic [7:0] hold, logic last);
    seg_t s;
    s.pin = pin;
    s.hold = hold;
    s.last = last;
    pending_segs.push_back(s);
  endfunction

  function automatic void push_bits(logic [7:0] v, int n);
    for (int k = n - 1; k >= 0; k--) begin
      if (v[k]) begin
        push_seg(1'b0, t_long, 1'b0);
        push_seg(1'b1, t_short, 1'b0);
      end else begin
        push_seg(1'b0, t_short, 1'b0);
        push_seg(1'b1, t_long, 1'b0);
      end
    end
  endfunction

  function automatic void predict_segments(logic cmd, logic [5:0] idx, logic [11:0] rgb,
                                           logic [7:0] lvl, logic fade);
    logic [5:0]  b;
    logic [11:0] col;
    logic [7:0]  sent;
    logic [3:0]  now;
    logic [3:0]  want;
    b = (idx > LAST_BULB) ? LAST_BULB : idx;
    if (cmd == CMD_SET) begin
      goal_col[b] = rgb;
      goal_lvl[b] = lvl;
      return;
    end
    if (goal_lvl[b] == shown_lvl[b] && goal_col[b] == shown_col[b]) return;
    col = goal_col[b];
    if (fade) begin
      for (int k = 0; k < 3; k++) begin
        now = shown_col[b][4*k +: 4];
        want = goal_col[b][4*k +: 4];
        col[4*k +: 4] = (want > now) ? now + 4'd1 : (want < now) ? now - 4'd1 : now;
      end
    end
    shown_lvl[b] = goal_lvl[b];
    shown_col[b] = col;
    sent = (goal_lvl[b] > lvl_cap) ? lvl_cap : goal_lvl[b];
    push_seg(1'b1, t_short, 1'b0);
    push_bits({2'b00, b}, 6);
    push_bits(sent, 8);
    push_bits({4'h0, col[11:8]}, 4);
    push_bits({4'h0, col[7:4]}, 4);
    push_bits({4'h0, col[3:0]}, 4);
    push_seg(1'b0, t_end, 1'b1);
  endfunction

  // receiver: random stall pattern, overridden by a counted hold-off
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      rx_hold = hold_len;
    end
    if (rx_phase == 0) begin
      rx_phase = $urandom_range(20, 200);
      rx_stall_pct = 25 * $urandom_range(0, 3);
    end else begin
      rx_phase--;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      m_tready <= 1'b0;
    end else if (rx_stall_pct == 0) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    seg_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_segs.size() == 0) begin
        report_mismatch("unexpected segment", int'({m_tlast, m_tdata}), 0);
      end else begin
        want = pending_segs.pop_front();
        if (m_tdata[0] !== want.pin)
          report_mismatch("pin_level", int'(m_tdata[0]), int'(want.pin));
        if (m_tdata[8:1] !== want.hold)
          report_mismatch("hold_us", int'(m_tdata[8:1]), int'(want.hold));
        if (m_tlast !== want.last)
          report_mismatch("frame_end", int'(m_tlast), int'(want.last));
      end
    end
  end

  task automatic send_word(logic cmd, logic [5:0] idx, logic [11:0] rgb, logic [7:0] lvl,
                           logic fade);
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {5'b0, fade, lvl, rgb, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_segments(cmd, idx, rgb, lvl, fade);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6))
        @(posedge clk);
      burst_left = $urandom_range(0, 15);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_segs.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic apb_write(reg_idx_t r, logic [7:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= {24'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (r)
      REG_SHORT_TIME: t_short = v;
      REG_LONG_TIME:  t_long = v;
      REG_END_TIME:   t_end = v;
      REG_BRIGHT_LIM: lvl_cap = v;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apb_check(reg_idx_t r, logic [7:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {r, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {24'h0, v}) report_mismatch("register read", int'(prdata), int'(v));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_timing(logic [7:0] s, logic [7:0] l, logic [7:0] e, logic [7:0] cap);
    wait_idle();
    apb_write(REG_SHORT_TIME, s);
    apb_write(REG_LONG_TIME, l);
    apb_write(REG_END_TIME, e);
    apb_write(REG_BRIGHT_LIM, cap);
  endtask

  function automatic logic [5:0] pick_bulb();
    logic [5:0] favourites [4] = '{6'd0, 6'd1, 6'd62, 6'd63};
    return ($urandom_range(0, 2) == 0) ? 6'($urandom_range(0, 63))
                                       : favourites[$urandom_range(0, 3)];
  endfunction

  function automatic logic [7:0] pick_level();
    int unsigned r;
    r = $urandom_range(0, 9);
    return (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : (r == 2) ? lvl_cap : 8'($urandom);
  endfunction

  task automatic random_words(int n);
    int         count;
    logic [5:0] b;
    count = 0;
    while (count < n) begin
      if ($urandom_range(0, 9) < 6) begin
        b = pick_bulb();
        send_word(CMD_SET, b, 12'($urandom), pick_level(), 1'($urandom));
        count++;
        repeat ($urandom_range(1, 3)) begin
          send_word(CMD_SERVICE, b, 12'($urandom), 8'($urandom), 1'($urandom));
          count++;
        end
      end else begin
        send_word(1'($urandom), pick_bulb(), 12'($urandom), 8'($urandom), 1'($urandom));
        count++;
      end
      if ($urandom_range(0, 19) == 0) wait_idle();
    end
  endtask

  task automatic test_register_readback();
    apb_check(REG_SHORT_TIME, 8'd10);
    apb_check(REG_LONG_TIME, 8'd20);
    apb_check(REG_END_TIME, 8'd30);
    apb_check(REG_BRIGHT_LIM, 8'd204);
    set_timing(8'd7, 8'd200, 8'd1, 8'd99);
    apb_check(REG_SHORT_TIME, 8'd7);
    apb_check(REG_LONG_TIME, 8'd200);
    apb_check(REG_END_TIME, 8'd1);
    apb_check(REG_BRIGHT_LIM, 8'd99);
    set_timing(8'd10, 8'd20, 8'd30, 8'd204);
  endtask

  task automatic test_directed_frames();
    send_word(CMD_SERVICE, 6'd0, 12'h000, 8'h00, 1'b0);
    send_word(CMD_SET, 6'd0, 12'hFFF, 8'hFF, 1'b0);
    send_word(CMD_SERVICE, 6'd0, 12'h000, 8'h00, 1'b0);
    send_word(CMD_SERVICE, 6'd0, 12'h000, 8'h00, 1'b0);
    send_word(CMD_SET, 6'd63, 12'hA5C, 8'h80, 1'b0);
    send_word(CMD_SERVICE, 6'd63, 12'h000, 8'h00, 1'b1);
    send_word(CMD_SERVICE, 6'd63, 12'h000, 8'h00, 1'b1);
    send_word(CMD_SERVICE, 6'd63, 12'hFFF, 8'hFF, 1'b0);
    send_word(CMD_SET, 6'd63, 12'h000, 8'h80, 1'b1);
    send_word(CMD_SERVICE, 6'd63, 12'h000, 8'h00, 1'b1);
    send_word(CMD_SET, 6'd1, 12'h000, 8'd204, 1'b0);
    send_word(CMD_SERVICE, 6'd1, 12'h000, 8'h00, 1'b0);
    send_word(CMD_SET, 6'd2, 12'h000, 8'd205, 1'b0);
    send_word(CMD_SERVICE, 6'd2, 12'h000, 8'h00, 1'b1);
    send_word(CMD_SET, 6'd3, 12'h000, 8'h00, 1'b0);
    send_word(CMD_SERVICE, 6'd3, 12'h000, 8'h00, 1'b0);
    send_word(CMD_SET, 6'd62, 12'h0F0, 8'h01, 1'b0);
    send_word(CMD_SERVICE, 6'd62, 12'h000, 8'h00, 1'b1);
    send_word(CMD_SET, 6'd0, 12'h000, 8'h00, 1'b0);
    send_word(CMD_SERVICE, 6'd0, 12'h000, 8'h00, 1'b0);
    send_word(CMD_SET, 6'd42, 12'h5A5, 8'h55, 1'b1);
    send_word(CMD_SERVICE, 6'd42, 12'hA5A, 8'hAA, 1'b0);
    wait_idle();
  endtask

  task automatic test_timing_extremes();
    set_timing(8'd1, 8'd1, 8'd1, 8'd0);
    random_words(30);
    set_timing(8'd255, 8'd255, 8'd255, 8'd255);
    random_words(30);
    set_timing(8'd0, 8'd255, 8'd0, 8'd128);
    random_words(20);
  endtask

  task automatic test_random_traffic();
    repeat (3) begin
      set_timing(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                 8'($urandom_range(1, 255)), 8'($urandom));
      random_words(40);
    end
  endtask

  task automatic test_backpressure_fill();
    logic [5:0] b [6];
    set_timing(8'd10, 8'd20, 8'd30, 8'd204);
    for (int k = 0; k < 6; k++) begin
      b[k] = 6'(10 + k);
      send_word(CMD_SET, b[k], 12'($urandom), 8'($urandom), 1'b0);
    end
    hold_len = 400;
    hold_seq++;
    for (int k = 0; k < 6; k++) begin
      send_word(CMD_SERVICE, b[k], 12'h000, 8'h00, 1'($urandom));
    end
    wait_idle();
  endtask

  initial begin
    for (int k = 0; k < BULB_COUNT; k++) begin
      goal_lvl[k] = '0;
      goal_col[k] = '0;
      shown_lvl[k] = '0;
      shown_col[k] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_readback();
    test_directed_frames();
    test_backpressure_fill();
    test_timing_extremes();
    test_random_traffic();
    wait_idle();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/lsft_pkg.sv
src/led_string_fade_and_frame_tx.sv
sim/led_string_fade_and_frame_tx_tb.sv
